[hw/rtl/mmmc_pkg.sv]
`default_nettype none

package mmmc_pkg;

  // Default widths of the sample fields.
  localparam int ACCEL_BITS_DEF = 14;
  localparam int TIME_BITS_DEF  = 32;

  // Fixed field widths.
  localparam int THR_BITS      = 14;
  localparam int TMR_BITS      = 32;
  localparam int TRACK_BITS    = 4;
  localparam int VOL_BITS      = 5;
  localparam int CFG_IDX_BITS  = 4;
  localparam int CFG_DATA_BITS = 32;

  // One g in sensor counts.
  localparam int ONE_G = 4096;

  // Meow intervals in milliseconds.
  localparam logic [TMR_BITS-1:0] IDLE_MEOW_MS = 32'd30000;
  localparam logic [TMR_BITS-1:0] HELD_MEOW_MS = 32'd20000;

  // Reset values of the configuration registers.
  localparam logic [THR_BITS-1:0] ANGRY_THR_RST     = 14'd8192;
  localparam logic [THR_BITS-1:0] HELD_THR_RST      = 14'd2048;
  localparam logic [THR_BITS-1:0] PURR_THR_RST      = 14'd2867;
  localparam logic [THR_BITS-1:0] QUIET_THR_RST     = 14'd614;
  localparam logic [TMR_BITS-1:0] HELD_TIMEOUT_RST  = 32'd30000;
  localparam logic [TMR_BITS-1:0] PURR_TIMEOUT_RST  = 32'd30000;
  localparam logic [TMR_BITS-1:0] ANGRY_DUR_RST     = 32'd15000;
  localparam logic [TMR_BITS-1:0] HELD_MIN_RST      = 32'd5000;

  // Configuration register indexes.
  localparam logic [CFG_IDX_BITS-1:0] REG_ANGRY_THR    = 4'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_HELD_THR     = 4'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_PURR_THR     = 4'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_QUIET_THR    = 4'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_HELD_TIMEOUT = 4'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_PURR_TIMEOUT = 4'd5;
  localparam logic [CFG_IDX_BITS-1:0] REG_ANGRY_DUR    = 4'd6;
  localparam logic [CFG_IDX_BITS-1:0] REG_HELD_MIN     = 4'd7;

  // Sound tracks and volumes.
  localparam logic [TRACK_BITS-1:0] TRACK_NONE  = 4'd0;
  localparam logic [TRACK_BITS-1:0] TRACK_HELD  = 4'd1;
  localparam logic [TRACK_BITS-1:0] TRACK_IDLE  = 4'd5;
  localparam logic [TRACK_BITS-1:0] TRACK_ANGRY = 4'd6;
  localparam logic [TRACK_BITS-1:0] TRACK_PURR  = 4'd7;
  localparam logic [VOL_BITS-1:0]   VOL_NONE    = 5'd0;
  localparam logic [VOL_BITS-1:0]   VOL_IDLE    = 5'd15;
  localparam logic [VOL_BITS-1:0]   VOL_HELD    = 5'd20;
  localparam logic [VOL_BITS-1:0]   VOL_ANGRY   = 5'd25;
  localparam logic [VOL_BITS-1:0]   VOL_PURR    = 5'd30;

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_HELD  = 2'd1,
    MODE_PURR  = 2'd2,
    MODE_ANGRY = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    SND_NONE = 2'd0,
    SND_PLAY = 2'd1,
    SND_LOOP = 2'd2,
    SND_STOP = 2'd3
  } snd_cmd_t;

  // Phases of the deviation unit sequencer.
  typedef enum logic [2:0] {
    PH_IDLE,
    PH_SQUARE,
    PH_SUM,
    PH_ROOT,
    PH_DONE
  } dev_phase_t;

endpackage

`default_nettype wire

[hw/rtl/mmmc_ifs.sv]
`default_nettype none

// Sample channel.
interface mmmc_in_if import mmmc_pkg::*; #(
  parameter int ACCEL_BITS = ACCEL_BITS_DEF,
  parameter int TIME_BITS  = TIME_BITS_DEF
) ();
  logic                         valid;
  logic                         ready;
  logic [TIME_BITS-1:0]         sample_time_ms;
  logic signed [ACCEL_BITS-1:0] accel_x;
  logic signed [ACCEL_BITS-1:0] accel_y;
  logic signed [ACCEL_BITS-1:0] accel_z;

  modport source (output valid, sample_time_ms, accel_x, accel_y, accel_z, input ready);
  modport sink   (input valid, sample_time_ms, accel_x, accel_y, accel_z, output ready);
endinterface

// Result channel.
interface mmmc_out_if import mmmc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  mode_t                 mode;
  logic                  heartbeat_on;
  logic                  purr_on;
  snd_cmd_t              sound_cmd;
  logic [TRACK_BITS-1:0] sound_track;
  logic [VOL_BITS-1:0]   sound_volume;

  modport source (output valid, mode, heartbeat_on, purr_on, sound_cmd, sound_track,
                  sound_volume, input ready);
  modport sink   (input valid, mode, heartbeat_on, purr_on, sound_cmd, sound_track,
                  sound_volume, output ready);
endinterface

// Configuration write channel.
interface mmmc_cfg_if import mmmc_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [CFG_IDX_BITS-1:0]  index;
  logic [CFG_DATA_BITS-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

[hw/rtl/mmmc_dev_unit.sv]
`default_nettype none

// Deviation of the acceleration magnitude from 1 g. One shared multiplier
// squares the three axes in turn, then a shared subtract and compare unit
// extracts the floor square root one bit per cycle.
module mmmc_dev_unit import mmmc_pkg::*; #(
  parameter int ACCEL_BITS = ACCEL_BITS_DEF,
  parameter int CMP_BITS   = (ACCEL_BITS > THR_BITS) ? ACCEL_BITS : THR_BITS
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  input  wire logic signed [ACCEL_BITS-1:0] accel_x,
  input  wire logic signed [ACCEL_BITS-1:0] accel_y,
  input  wire logic signed [ACCEL_BITS-1:0] accel_z,
  input  wire logic                         ack,
  output logic                              idle,
  output logic                              done,
  output logic [CMP_BITS-1:0]               dev
);

  localparam int SQ_BITS   = 2 * ACCEL_BITS;
  localparam int REM_BITS  = ACCEL_BITS + 1;
  localparam int TRY_BITS  = ACCEL_BITS + 3;
  localparam int STEP_BITS = $clog2(ACCEL_BITS);

  dev_phase_t                   phase_r, phase_nxt;
  logic [STEP_BITS-1:0]         step_r, step_nxt;
  logic signed [ACCEL_BITS-1:0] ax_r, ay_r, az_r;
  logic signed [ACCEL_BITS-1:0] mul_op;
  logic signed [SQ_BITS-1:0]    mul_res;
  logic [SQ_BITS-1:0]           prod_r, prod_nxt;
  logic [SQ_BITS-1:0]           acc_r, acc_nxt;
  logic [SQ_BITS-1:0]           n_r, n_nxt;
  logic [REM_BITS-1:0]          rem_r, rem_nxt;
  logic [ACCEL_BITS-1:0]        root_r, root_nxt;
  logic [TRY_BITS-1:0]          rem_try;
  logic [TRY_BITS-1:0]          trial;
  logic                         fits;
  logic [CMP_BITS-1:0]          root_ext;

  // Axis selection for the shared multiplier.
  always_comb begin
    case (step_r[1:0])
      2'd0:    mul_op = ax_r;
      2'd1:    mul_op = ay_r;
      default: mul_op = az_r;
    endcase
  end

  assign mul_res = mul_op * mul_op;

  // One digit of the square root: shift in two radicand bits and try the
  // next root bit.
  assign rem_try = {rem_r, n_r[SQ_BITS-1 -: 2]};
  assign trial   = TRY_BITS'({root_r, 2'b01});
  assign fits    = (rem_try >= trial);

  // Phase sequencer.
  always_comb begin
    phase_nxt = phase_r;
    step_nxt  = step_r;
    prod_nxt  = prod_r;
    acc_nxt   = acc_r;
    n_nxt     = n_r;
    rem_nxt   = rem_r;
    root_nxt  = root_r;
    unique case (phase_r)
      PH_IDLE: begin
        if (start) begin
          phase_nxt = PH_SQUARE;
          step_nxt  = '0;
        end
      end
      PH_SQUARE: begin
        prod_nxt = SQ_BITS'(mul_res);
        acc_nxt  = (step_r == '0) ? '0 : acc_r + prod_r;
        step_nxt = step_r + 1'b1;
        if (step_r == STEP_BITS'(2)) begin
          phase_nxt = PH_SUM;
        end
      end
      PH_SUM: begin
        n_nxt     = acc_r + prod_r;
        rem_nxt   = '0;
        root_nxt  = '0;
        step_nxt  = STEP_BITS'(ACCEL_BITS - 1);
        phase_nxt = PH_ROOT;
      end
      PH_ROOT: begin
        n_nxt    = n_r << 2;
        rem_nxt  = fits ? REM_BITS'(rem_try - trial) : REM_BITS'(rem_try);
        root_nxt = {root_r[ACCEL_BITS-2:0], fits};
        step_nxt = step_r - 1'b1;
        if (step_r == '0) begin
          phase_nxt = PH_DONE;
        end
      end
      PH_DONE: begin
        if (ack) begin
          phase_nxt = PH_IDLE;
        end
      end
      default: phase_nxt = PH_IDLE;
    endcase
  end

  // Sequencer state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
    end else begin
      phase_r <= phase_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    step_r <= step_nxt;
    prod_r <= prod_nxt;
    acc_r  <= acc_nxt;
    n_r    <= n_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
    if (start && phase_r == PH_IDLE) begin
      ax_r <= accel_x;
      ay_r <= accel_y;
      az_r <= accel_z;
    end
  end

  // Absolute distance of the root from one g.
  assign root_ext = CMP_BITS'(root_r);
  assign dev      = (root_ext >= CMP_BITS'(ONE_G)) ? root_ext - CMP_BITS'(ONE_G)
                                                   : CMP_BITS'(ONE_G) - root_ext;
  assign idle     = (phase_r == PH_IDLE);
  assign done     = (phase_r == PH_DONE);

  // A start in the idle phase always begins squaring.
  a_start_in_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start && idle |=> phase_r == PH_SQUARE)
    else $error("deviation unit did not begin squaring after start");

  // The root digit counter is loaded with ACCEL_BITS - 1 as the root phase begins.
  a_root_len: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_SUM |=> step_r == STEP_BITS'(ACCEL_BITS - 1))
    else $error("root digit counter not loaded");

  // The result stays until it is taken.
  a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
    done && !ack |=> done && $stable(root_r))
    else $error("deviation result lost before it was taken");

endmodule

`default_nettype wire

[hw/rtl/motion_mood_mode_controller.sv]
`default_nettype none

// Channel  Role  Payload
// in_if    sink  sample_time_ms, accel_x, accel_y, accel_z
// out_if   src   mode, heartbeat_on, purr_on, sound_cmd, sound_track, sound_volume
// cfg_if   sink  index, data (ready whenever out of reset)
//
// After its transfer, a sample has its three axes squared in turn on the shared
// multiplier, is summed, and is rooted one bit per cycle; the decision cycle
// then registers its result and the next mode in the output register.
// The next sample is taken as soon as the decision cycle has loaded the result,
// while the result waits in the output register.
// A stalled output holds the decision cycle, and with it the next sample.
// Reset is synchronous, active low, and restores idle mode and register defaults.
module motion_mood_mode_controller import mmmc_pkg::*; #(
  parameter int ACCEL_BITS = ACCEL_BITS_DEF,
  parameter int TIME_BITS  = TIME_BITS_DEF
) (
  input wire logic clk,
  input wire logic rst_n,
  mmmc_in_if.sink   in_if,
  mmmc_out_if.source out_if,
  mmmc_cfg_if.sink  cfg_if
);

  localparam int CMP_BITS = (ACCEL_BITS > THR_BITS) ? ACCEL_BITS : THR_BITS;

  // Configuration registers.
  logic [THR_BITS-1:0] angry_thr_r, held_thr_r, purr_thr_r, quiet_thr_r;
  logic [TMR_BITS-1:0] held_timeout_r, purr_timeout_r, angry_dur_r, held_min_r;

  // Mood state.
  mode_t                mode_r, mode_nxt;
  logic [TIME_BITS-1:0] last_meow_r, last_meow_nxt;
  logic [TIME_BITS-1:0] mode_entry_r, mode_entry_nxt;
  logic                 angry_done_r, angry_done_nxt;
  logic                 purr_active_r, purr_active_nxt;
  logic [TIME_BITS-1:0] now_r;

  // Output register.
  logic                  out_valid_r;
  mode_t                 out_mode_r;
  logic                  out_heart_r;
  logic                  out_purr_r;
  snd_cmd_t              out_cmd_r, cmd;
  logic [TRACK_BITS-1:0] out_track_r, track;
  logic [VOL_BITS-1:0]   out_vol_r, vol;

  logic                 in_xfer;
  logic                 dev_idle, dev_done, decide;
  logic [CMP_BITS-1:0]  dev;
  logic [TIME_BITS-1:0] meow_el, since;
  logic [TMR_BITS-1:0]  meow_el_ext, since_ext;
  logic                 gt_angry, gt_held, gt_purr, lt_quiet;

  assign in_xfer     = in_if.valid && in_if.ready;
  assign in_if.ready = dev_idle && rst_n;
  assign decide      = dev_done && (!out_valid_r || out_if.ready);

  mmmc_dev_unit #(
    .ACCEL_BITS (ACCEL_BITS),
    .CMP_BITS   (CMP_BITS)
  ) u_dev (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (in_xfer),
    .accel_x (in_if.accel_x),
    .accel_y (in_if.accel_y),
    .accel_z (in_if.accel_z),
    .ack     (decide),
    .idle    (dev_idle),
    .done    (dev_done),
    .dev     (dev)
  );

  // Timestamp of the sample in progress.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      now_r <= in_if.sample_time_ms;
    end
  end

  // Configuration writes; unknown indexes are dropped.
  assign cfg_if.ready = rst_n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      angry_thr_r    <= ANGRY_THR_RST;
      held_thr_r     <= HELD_THR_RST;
      purr_thr_r     <= PURR_THR_RST;
      quiet_thr_r    <= QUIET_THR_RST;
      held_timeout_r <= HELD_TIMEOUT_RST;
      purr_timeout_r <= PURR_TIMEOUT_RST;
      angry_dur_r    <= ANGRY_DUR_RST;
      held_min_r     <= HELD_MIN_RST;
    end else if (cfg_if.valid) begin
      unique case (cfg_if.index)
        REG_ANGRY_THR:    angry_thr_r    <= cfg_if.data[THR_BITS-1:0];
        REG_HELD_THR:     held_thr_r     <= cfg_if.data[THR_BITS-1:0];
        REG_PURR_THR:     purr_thr_r     <= cfg_if.data[THR_BITS-1:0];
        REG_QUIET_THR:    quiet_thr_r    <= cfg_if.data[THR_BITS-1:0];
        REG_HELD_TIMEOUT: held_timeout_r <= cfg_if.data[TMR_BITS-1:0];
        REG_PURR_TIMEOUT: purr_timeout_r <= cfg_if.data[TMR_BITS-1:0];
        REG_ANGRY_DUR:    angry_dur_r    <= cfg_if.data[TMR_BITS-1:0];
        REG_HELD_MIN:     held_min_r     <= cfg_if.data[TMR_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Wrapping elapsed times and threshold compares.
  assign meow_el     = now_r - last_meow_r;
  assign since       = now_r - mode_entry_r;
  assign meow_el_ext = TMR_BITS'(meow_el);
  assign since_ext   = TMR_BITS'(since);
  assign gt_angry    = dev > CMP_BITS'(angry_thr_r);
  assign gt_held     = dev > CMP_BITS'(held_thr_r);
  assign gt_purr     = dev > CMP_BITS'(purr_thr_r);
  assign lt_quiet    = dev < CMP_BITS'(quiet_thr_r);

  // Mode transitions and the sound command of one sample.
  always_comb begin
    mode_nxt        = mode_r;
    last_meow_nxt   = last_meow_r;
    mode_entry_nxt  = mode_entry_r;
    angry_done_nxt  = angry_done_r;
    purr_active_nxt = purr_active_r;
    cmd             = SND_NONE;
    track           = TRACK_NONE;
    vol             = VOL_NONE;
    unique case (mode_r)
      MODE_IDLE: begin
        if (meow_el_ext > IDLE_MEOW_MS) begin
          cmd           = SND_PLAY;
          track         = TRACK_IDLE;
          vol           = VOL_IDLE;
          last_meow_nxt = now_r;
        end
        if (gt_angry) begin
          mode_nxt       = MODE_ANGRY;
          mode_entry_nxt = now_r;
        end else if (gt_held) begin
          mode_nxt       = MODE_HELD;
          mode_entry_nxt = now_r;
        end
      end
      MODE_HELD: begin
        if (meow_el_ext > HELD_MEOW_MS) begin
          cmd           = SND_PLAY;
          track         = TRACK_HELD;
          vol           = VOL_HELD;
          last_meow_nxt = now_r;
        end
        if (lt_quiet) begin
          if (since_ext > held_timeout_r) begin
            mode_nxt       = MODE_IDLE;
            mode_entry_nxt = now_r;
          end
        end else if (gt_angry) begin
          mode_nxt       = MODE_ANGRY;
          mode_entry_nxt = now_r;
        end else if (gt_purr && since_ext > held_min_r) begin
          mode_nxt       = MODE_PURR;
          mode_entry_nxt = now_r;
        end
      end
      MODE_PURR: begin
        if (!purr_active_r) begin
          cmd   = SND_LOOP;
          track = TRACK_PURR;
          vol   = VOL_PURR;
        end
        purr_active_nxt = 1'b1;
        // Leaving purring stops the loop, even one started in this step.
        if (gt_angry) begin
          purr_active_nxt = 1'b0;
          mode_nxt        = MODE_ANGRY;
          mode_entry_nxt  = now_r;
          cmd             = SND_STOP;
          track           = TRACK_NONE;
          vol             = VOL_NONE;
        end else if (gt_purr) begin
          mode_entry_nxt = now_r;
        end else if (lt_quiet && since_ext > purr_timeout_r) begin
          purr_active_nxt = 1'b0;
          mode_nxt        = MODE_HELD;
          mode_entry_nxt  = now_r;
          cmd             = SND_STOP;
          track           = TRACK_NONE;
          vol             = VOL_NONE;
        end
      end
      MODE_ANGRY: begin
        if (!angry_done_r) begin
          cmd            = SND_PLAY;
          track          = TRACK_ANGRY;
          vol            = VOL_ANGRY;
          angry_done_nxt = 1'b1;
        end
        if (since_ext > angry_dur_r) begin
          angry_done_nxt = 1'b0;
          mode_nxt       = MODE_IDLE;
          mode_entry_nxt = now_r;
        end
      end
      default: mode_nxt = MODE_IDLE;
    endcase
  end

  // Mood state registers, updated once per sample.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r        <= MODE_IDLE;
      last_meow_r   <= '0;
      mode_entry_r  <= '0;
      angry_done_r  <= 1'b0;
      purr_active_r <= 1'b0;
    end else if (decide) begin
      mode_r        <= mode_nxt;
      last_meow_r   <= last_meow_nxt;
      mode_entry_r  <= mode_entry_nxt;
      angry_done_r  <= angry_done_nxt;
      purr_active_r <= purr_active_nxt;
    end
  end

  // Output register; drive flags follow the mode the step began in.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (decide) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (decide) begin
      out_mode_r  <= mode_nxt;
      out_heart_r <= (mode_r != MODE_PURR);
      out_purr_r  <= (mode_r == MODE_PURR);
      out_cmd_r   <= cmd;
      out_track_r <= track;
      out_vol_r   <= vol;
    end
  end

  assign out_if.valid        = out_valid_r;
  assign out_if.mode         = out_mode_r;
  assign out_if.heartbeat_on = out_heart_r;
  assign out_if.purr_on      = out_purr_r;
  assign out_if.sound_cmd    = out_cmd_r;
  assign out_if.sound_track  = out_track_r;
  assign out_if.sound_volume = out_vol_r;

  // A transfer makes the block busy until its result is loaded.
  a_busy_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> !in_if.ready)
    else $error("sample taken while another was in progress");

  // The purr loop flag only lives in purring mode.
  a_purr_flag: assert property (@(posedge clk) disable iff (!rst_n)
    purr_active_r |-> mode_r == MODE_PURR)
    else $error("purr loop flag set outside purring mode");

  // The angry sound flag only lives in angry mode.
  a_angry_flag: assert property (@(posedge clk) disable iff (!rst_n)
    angry_done_r |-> mode_r == MODE_ANGRY)
    else $error("angry sound flag set outside angry mode");

  // A stop carries no track and no volume.
  a_stop_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_cmd_r == SND_STOP |-> out_track_r == TRACK_NONE &&
                                             out_vol_r == VOL_NONE)
    else $error("stop command with a track or volume");

  // A pending result is not overwritten.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_if.ready |=> out_valid_r && $stable(out_cmd_r))
    else $error("pending result changed before its transfer");

endmodule

`default_nettype wire

[sim/tb_top.sv]
`timescale 1ns / 1ps

module tb_top import mmmc_pkg::*; ();

  localparam int CYCLE_LIMIT  = 400000;
  localparam int LONG_HOLD    = 300;
  localparam int DRAIN_CYCLES = 40;
  localparam int MAX_REPORTS  = 10;
  localparam int NUM_REGS     = REG_HELD_MIN + 1;

  typedef struct packed {
    logic [TIME_BITS_DEF-1:0]         t_ms;
    logic signed [ACCEL_BITS_DEF-1:0] ax;
    logic signed [ACCEL_BITS_DEF-1:0] ay;
    logic signed [ACCEL_BITS_DEF-1:0] az;
  } sample_t;

  typedef struct packed {
    mode_t                 mode;
    logic                  heartbeat_on;
    logic                  purr_on;
    snd_cmd_t              sound_cmd;
    logic [TRACK_BITS-1:0] sound_track;
    logic [VOL_BITS-1:0]   sound_volume;
  } mood_result_t;

  logic clk;
  logic rst_n;

  mmmc_in_if #(.ACCEL_BITS(ACCEL_BITS_DEF), .TIME_BITS(TIME_BITS_DEF)) sample_ch ();
  mmmc_out_if mood_ch ();
  mmmc_cfg_if reg_ch ();

  motion_mood_mode_controller DUT (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (sample_ch),
    .out_if(mood_ch),
    .cfg_if(reg_ch)
  );

  // Mirror of the configuration registers.
  logic [THR_BITS-1:0] thr_angry = ANGRY_THR_RST;
  logic [THR_BITS-1:0] thr_held  = HELD_THR_RST;
  logic [THR_BITS-1:0] thr_purr  = PURR_THR_RST;
  logic [THR_BITS-1:0] thr_quiet = QUIET_THR_RST;
  logic [TMR_BITS-1:0] held_timeout = HELD_TIMEOUT_RST;
  logic [TMR_BITS-1:0] purr_timeout = PURR_TIMEOUT_RST;
  logic [TMR_BITS-1:0] angry_dur    = ANGRY_DUR_RST;
  logic [TMR_BITS-1:0] held_min     = HELD_MIN_RST;

  // Mirror of the mood state.
  mode_t               cur_mode     = MODE_IDLE;
  logic [TMR_BITS-1:0] last_meow_ms = '0;
  logic [TMR_BITS-1:0] entry_ms     = '0;
  bit                  angry_played = 1'b0;
  bit                  purr_looping = 1'b0;

  mood_result_t moods_due[$];
  logic [TMR_BITS-1:0] now_ms = '0;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_reqs = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int samples_sent = 0;
  int results_checked = 0;
  int reg_writes = 0;
  int mismatches = 0;
  int mode_seen[4] = '{default: 0};
  int cmd_seen[4] = '{default: 0};

  // Clock.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Watchdog on the whole run.
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Watchdog expired after %0d cycles with %0d results outstanding.",
             CYCLE_LIMIT, moods_due.size());
    $display("** motion_mood_mode_controller: FAILED **");
    $finish;
  end

  // Computes the result of one sample and advances the mirrored mood state.
  function automatic mood_result_t predict_mood(input sample_t s);
    int sx, sy, sz, dev, bitpos;
    logic [31:0] sq, trial, root;
    logic [TMR_BITS-1:0] since_entry, since_meow;
    mode_t entry;
    mood_result_t r;
    sx = $signed(s.ax);
    sy = $signed(s.ay);
    sz = $signed(s.az);
    sq = sx * sx + sy * sy + sz * sz;
    root = '0;
    for (bitpos = 15; bitpos >= 0; bitpos--) begin
      trial = root | (32'd1 << bitpos);
      if (trial * trial <= sq) root = trial;
    end
    dev = (int'(root) >= ONE_G) ? int'(root) - ONE_G : ONE_G - int'(root);
    entry = cur_mode;
    since_entry = s.t_ms - entry_ms;
    since_meow = s.t_ms - last_meow_ms;
    r.sound_cmd = SND_NONE;
    r.sound_track = TRACK_NONE;
    r.sound_volume = VOL_NONE;

    case (entry)
      MODE_IDLE: begin
        if (since_meow > IDLE_MEOW_MS) begin
          r.sound_cmd = SND_PLAY;
          r.sound_track = TRACK_IDLE;
          r.sound_volume = VOL_IDLE;
          last_meow_ms = s.t_ms;
        end
        if (dev > int'(thr_angry)) begin
          cur_mode = MODE_ANGRY;
          entry_ms = s.t_ms;
        end else if (dev > int'(thr_held)) begin
          cur_mode = MODE_HELD;
          entry_ms = s.t_ms;
        end
      end
      MODE_HELD: begin
        if (since_meow > HELD_MEOW_MS) begin
          r.sound_cmd = SND_PLAY;
          r.sound_track = TRACK_HELD;
          r.sound_volume = VOL_HELD;
          last_meow_ms = s.t_ms;
        end
        if (dev < int'(thr_quiet)) begin
          if (since_entry > held_timeout) begin
            cur_mode = MODE_IDLE;
            entry_ms = s.t_ms;
          end
        end else if (dev > int'(thr_angry)) begin
          cur_mode = MODE_ANGRY;
          entry_ms = s.t_ms;
        end else if (dev > int'(thr_purr) && since_entry > held_min) begin
          cur_mode = MODE_PURR;
          entry_ms = s.t_ms;
        end
      end
      MODE_PURR: begin
        if (!purr_looping) begin
          r.sound_cmd = SND_LOOP;
          r.sound_track = TRACK_PURR;
          r.sound_volume = VOL_PURR;
        end
        purr_looping = 1'b1;
        // Leaving purring stops the loop, even one started in this same step.
        if (dev > int'(thr_angry)) begin
          purr_looping = 1'b0;
          cur_mode = MODE_ANGRY;
          entry_ms = s.t_ms;
          r.sound_cmd = SND_STOP;
          r.sound_track = TRACK_NONE;
          r.sound_volume = VOL_NONE;
        end else if (dev > int'(thr_purr)) begin
          entry_ms = s.t_ms;
        end else if (dev < int'(thr_quiet) && since_entry > purr_timeout) begin
          purr_looping = 1'b0;
          cur_mode = MODE_HELD;
          entry_ms = s.t_ms;
          r.sound_cmd = SND_STOP;
          r.sound_track = TRACK_NONE;
          r.sound_volume = VOL_NONE;
        end
      end
      default: begin
        if (!angry_played) begin
          r.sound_cmd = SND_PLAY;
          r.sound_track = TRACK_ANGRY;
          r.sound_volume = VOL_ANGRY;
          angry_played = 1'b1;
        end
        if (since_entry > angry_dur) begin
          angry_played = 1'b0;
          cur_mode = MODE_IDLE;
          entry_ms = s.t_ms;
        end
      end
    endcase

    // The drives follow the mode the step started in.
    r.mode = cur_mode;
    r.heartbeat_on = (entry != MODE_PURR);
    r.purr_on = (entry == MODE_PURR);
    mode_seen[r.mode]++;
    cmd_seen[r.sound_cmd]++;
    return r;
  endfunction

  function automatic sample_t make_sample(input logic [TIME_BITS_DEF-1:0] t, input int x,
                                          input int y, input int z);
    sample_t s;
    s.t_ms = t;
    s.ax = ACCEL_BITS_DEF'(x);
    s.ay = ACCEL_BITS_DEF'(y);
    s.az = ACCEL_BITS_DEF'(z);
    return s;
  endfunction

  // Builds a sample whose magnitude lies about dev counts from 1 g.
  function automatic sample_t shape_sample(input logic [TIME_BITS_DEF-1:0] t, input int dev);
    int mag, comp, jit, rot;
    int axis[3];
    mag = ($urandom_range(1) == 1 && dev <= ONE_G) ? ONE_G - dev : ONE_G + dev;
    if (mag <= 8000) begin
      // Mostly along one axis, with a little spread on the others.
      jit = mag / 50;
      axis[0] = int'($urandom_range(2 * jit)) - jit;
      axis[1] = int'($urandom_range(2 * jit)) - jit;
      axis[2] = ($urandom_range(1) == 1) ? mag : -mag;
    end else begin
      // Too large for one axis: spread evenly over all three.
      comp = mag * 577 / 1000;
      if (comp > 8191) comp = 8191;
      for (int k = 0; k < 3; k++) begin
        jit = comp - int'($urandom_range(40));
        axis[k] = ($urandom_range(1) == 1) ? jit : -jit;
      end
    end
    rot = $urandom_range(2);
    return make_sample(t, axis[rot], axis[(rot + 1) % 3], axis[(rot + 2) % 3]);
  endfunction

  // Chooses a deviation across the threshold bands, quiet handling the most likely one.
  function automatic int pick_dev();
    int roll, pick;
    roll = $urandom_range(99);
    if (roll < 35) begin
      pick = $urandom_range(thr_quiet);
    end else if (roll < 55) begin
      case ($urandom_range(3))
        0: pick = thr_quiet;
        1: pick = thr_held;
        2: pick = thr_purr;
        default: pick = thr_angry;
      endcase
      pick += int'($urandom_range(300)) - 150;
    end else if (roll < 72) begin
      pick = $urandom_range(thr_held, thr_purr);
    end else if (roll < 95) begin
      pick = $urandom_range(thr_purr, thr_angry);
    end else begin
      pick = int'(thr_angry) + int'($urandom_range(1, 2000));
    end
    if (pick < 0) pick = 0;
    return pick;
  endfunction

  // Mostly short steps of time, some long ones and a few arbitrary jumps.
  function automatic logic [TMR_BITS-1:0] pick_step();
    int roll;
    roll = $urandom_range(99);
    if (roll < 85) return $urandom_range(50, 4000);
    if (roll < 97) return $urandom_range(4000, 45000);
    return $urandom();
  endfunction

  // Offers one sample and records its expected result at the transfer.
  task automatic send_sample(input sample_t s);
    while ($urandom_range(99) < send_idle_pct) begin
      sample_ch.valid <= 1'b0;
      @(posedge clk);
    end
    sample_ch.valid <= 1'b1;
    sample_ch.sample_time_ms <= s.t_ms;
    sample_ch.accel_x <= s.ax;
    sample_ch.accel_y <= s.ay;
    sample_ch.accel_z <= s.az;
    do @(posedge clk); while (!sample_ch.ready);
    moods_due.push_back(predict_mood(s));
    samples_sent++;
  endtask

  // Stops offering samples until every expected result has come back.
  task automatic wait_moods_drained();
    sample_ch.valid <= 1'b0;
    do @(posedge clk); while (moods_due.size() != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] val);
    reg_ch.valid <= 1'b1;
    reg_ch.index <= idx;
    reg_ch.data <= val;
    do @(posedge clk); while (!reg_ch.ready);
    reg_ch.valid <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_ANGRY_THR:    thr_angry = val[THR_BITS-1:0];
      REG_HELD_THR:     thr_held = val[THR_BITS-1:0];
      REG_PURR_THR:     thr_purr = val[THR_BITS-1:0];
      REG_QUIET_THR:    thr_quiet = val[THR_BITS-1:0];
      REG_HELD_TIMEOUT: held_timeout = val;
      REG_PURR_TIMEOUT: purr_timeout = val;
      REG_ANGRY_DUR:    angry_dur = val;
      REG_HELD_MIN:     held_min = val;
      default: ;
    endcase
    reg_writes++;
  endtask

  task automatic run_mood_traffic(input int count);
    sample_t s;
    for (int k = 0; k < count; k++) begin
      now_ms += pick_step();
      s = shape_sample(now_ms, pick_dev());
      // A few samples carry arbitrary readings on every axis.
      if ($urandom_range(99) < 7) begin
        s.ax = ACCEL_BITS_DEF'($urandom());
        s.ay = ACCEL_BITS_DEF'($urandom());
        s.az = ACCEL_BITS_DEF'($urandom());
      end
      send_sample(s);
    end
  endtask

  // Walks every mode and sound with the reset settings, then the field extremes.
  task automatic test_directed_moods();
    send_idle_pct = 13;
    recv_idle_pct = 81;
    send_sample(make_sample(32'd0, 0, 0, 4096));
    send_sample(make_sample(32'd30001, 0, 0, 4096));
    send_sample(make_sample(32'd31000, 0, 0, 6596));
    send_sample(make_sample(32'd32000, 0, 0, 7596));
    send_sample(make_sample(32'd40000, 0, 0, -7596));
    send_sample(make_sample(32'd41000, 0, 0, 4096));
    send_sample(make_sample(32'd42000, 0, 7596, 0));
    send_sample(make_sample(32'd80000, 0, 0, 4096));
    send_sample(make_sample(32'd81000, 8191, 8191, 8191));
    send_sample(make_sample(32'd82000, 0, 0, 4096));
    send_sample(make_sample(32'd83000, 0, 0, 4096));
    send_sample(make_sample(32'd100000, 0, 0, 4096));
    send_sample(make_sample(32'd101000, 6596, 0, 0));
    send_sample(make_sample(32'd110000, 0, 0, 7596));
    // Purring is left for angry in its first step, stopping the loop that it starts.
    send_sample(make_sample(32'd111000, -8192, -8192, -8192));
    send_sample(make_sample(32'd112000, 0, 0, 4096));
    send_sample(make_sample(32'd130000, 0, 0, 4096));
    send_sample(make_sample(32'd131000, 0, 0, 0));
    send_sample(make_sample(32'd170000, 0, 0, 4096));
    // Time stamps across the wrap of the millisecond counter.
    send_sample(make_sample(32'hFFFF_FFFF, 0, 0, 4096));
    send_sample(make_sample(32'h0000_1000, 0, 0, 4096));
    send_sample(make_sample(32'h0000_8000, -8192, 8191, -8192));
    send_sample(make_sample(32'h8000_0000, 8191, -8192, 8191));
    now_ms = 32'h8000_0000;
  endtask

  // All registers at zero, then all at their largest values.
  task automatic test_register_extremes();
    wait_moods_drained();
    for (int r = 0; r < NUM_REGS; r++) write_reg(CFG_IDX_BITS'(r), '0);
    // An index past the register list must leave everything unchanged.
    write_reg(CFG_IDX_BITS'($urandom_range(15, NUM_REGS)), $urandom());
    run_mood_traffic(25);
    wait_moods_drained();
    for (int r = 0; r < NUM_REGS; r++) write_reg(CFG_IDX_BITS'(r), '1);
    run_mood_traffic(25);
  endtask

  // Random settings under the three idling patterns.
  task automatic test_random_moods();
    logic [THR_BITS-1:0] thr;
    for (int ph = 0; ph < 3; ph++) begin
      wait_moods_drained();
      case (ph)
        0: begin
          send_idle_pct = 13;
          recv_idle_pct = 81;
        end
        1: begin
          send_idle_pct = 81;
          recv_idle_pct = 13;
          now_ms = 32'hFFFF_0000 + $urandom_range(20000);
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      // Upper data bits are set at random on the 14 bit registers.
      thr = $urandom_range(100, 1200);
      write_reg(REG_QUIET_THR, ($urandom() & 32'hFFFF_C000) | thr);
      thr = $urandom_range(1200, 3000);
      write_reg(REG_HELD_THR, ($urandom() & 32'hFFFF_C000) | thr);
      thr = $urandom_range(2500, 5000);
      write_reg(REG_PURR_THR, ($urandom() & 32'hFFFF_C000) | thr);
      thr = $urandom_range(5000, 11000);
      write_reg(REG_ANGRY_THR, ($urandom() & 32'hFFFF_C000) | thr);
      write_reg(REG_HELD_TIMEOUT, $urandom_range(2000, 40000));
      write_reg(REG_PURR_TIMEOUT, $urandom_range(2000, 40000));
      write_reg(REG_ANGRY_DUR, $urandom_range(1000, 20000));
      write_reg(REG_HELD_MIN, $urandom_range(0, 10000));
      run_mood_traffic(130);
    end
  endtask

  // The result side holds off for a long stretch while samples keep coming,
  // then the sample side pauses until everything has come back.
  task automatic test_backpressure();
    wait_moods_drained();
    write_reg(REG_ANGRY_THR, ANGRY_THR_RST);
    write_reg(REG_HELD_THR, HELD_THR_RST);
    write_reg(REG_PURR_THR, PURR_THR_RST);
    write_reg(REG_QUIET_THR, QUIET_THR_RST);
    write_reg(REG_HELD_TIMEOUT, HELD_TIMEOUT_RST);
    write_reg(REG_PURR_TIMEOUT, PURR_TIMEOUT_RST);
    write_reg(REG_ANGRY_DUR, ANGRY_DUR_RST);
    write_reg(REG_HELD_MIN, HELD_MIN_RST);
    send_idle_pct = 0;
    recv_idle_pct = 20;
    hold_reqs <= hold_reqs + 1;
    run_mood_traffic(40);
    wait_moods_drained();
    run_mood_traffic(30);
  endtask

  // Result side readiness: random idling, or a long hold when requested.
  always @(posedge clk) begin
    if (hold_seen != hold_reqs) begin
      hold_seen <= hold_reqs;
      hold_left <= LONG_HOLD;
      mood_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      mood_ch.ready <= 1'b0;
    end else begin
      mood_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Compares each result transfer with the oldest expected result.
  always @(posedge clk) begin : check_results
    mood_result_t want;
    mood_result_t got;
    if (rst_n && mood_ch.valid && mood_ch.ready) begin
      got.mode = mood_ch.mode;
      got.heartbeat_on = mood_ch.heartbeat_on;
      got.purr_on = mood_ch.purr_on;
      got.sound_cmd = mood_ch.sound_cmd;
      got.sound_track = mood_ch.sound_track;
      got.sound_volume = mood_ch.sound_volume;
      if (moods_due.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("Unexpected result at %0t: mode %0d cmd %0d", $realtime,
                   got.mode, got.sound_cmd);
      end else begin
        want = moods_due.pop_front();
        results_checked++;
        if (got.mode !== want.mode || got.heartbeat_on !== want.heartbeat_on ||
            got.purr_on !== want.purr_on || got.sound_cmd !== want.sound_cmd ||
            got.sound_track !== want.sound_track ||
            got.sound_volume !== want.sound_volume) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("Result %0d mismatch:", results_checked);
            $display("  expected mode %0d hb %0d purr %0d cmd %0d track %0d vol %0d",
                     want.mode, want.heartbeat_on, want.purr_on, want.sound_cmd,
                     want.sound_track, want.sound_volume);
            $display("  got      mode %0d hb %0d purr %0d cmd %0d track %0d vol %0d",
                     got.mode, got.heartbeat_on, got.purr_on, got.sound_cmd,
                     got.sound_track, got.sound_volume);
          end
        end
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    sample_ch.valid = 1'b0;
    sample_ch.sample_time_ms = '0;
    sample_ch.accel_x = '0;
    sample_ch.accel_y = '0;
    sample_ch.accel_z = '0;
    mood_ch.ready = 1'b0;
    reg_ch.valid = 1'b0;
    reg_ch.index = '0;
    reg_ch.data = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_moods();
    test_register_extremes();
    test_random_moods();
    test_backpressure();

    wait_moods_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d samples, %0d register writes, %0d results checked; modes %0d/%0d/%0d/%0d.",
             samples_sent, reg_writes, results_checked, mode_seen[MODE_IDLE],
             mode_seen[MODE_HELD], mode_seen[MODE_PURR], mode_seen[MODE_ANGRY]);
    $display("Sound commands none/play/loop/stop %0d/%0d/%0d/%0d.",
             cmd_seen[SND_NONE], cmd_seen[SND_PLAY], cmd_seen[SND_LOOP],
             cmd_seen[SND_STOP]);
    if (mismatches == 0 && moods_due.size() == 0) begin
      $display("** motion_mood_mode_controller: PASSED **");
    end else begin
      $display("** motion_mood_mode_controller: FAILED **");
    end
    $finish;
  end

endmodule
